// ===== rtl/phtc_pkg.sv =====
package phtc_pkg;

    // Datapath widths
    localparam int ERR_W    = 17;
    localparam int DIFF_W   = 18;
    localparam int INTEG_W  = 40;
    localparam int SUM_W    = 48;
    localparam int MA_W     = 25;
    localparam int MB_W     = 17;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int HI_SHIFT = 24;
    localparam int ACC_W    = 66;
    localparam int STEP_W   = 4;

    // Saturation limits
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SUM_MAX_A =
        {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SUM_MIN_A = -SUM_MAX_A;
    localparam logic signed [ACC_W-1:0] ROUND_HALF  = ACC_W'(256);
    localparam int                      DRIVE_SHIFT = 9;
    localparam logic signed [ACC_W-1:0] DRIVE_MAX_A = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] DRIVE_MIN_A = -DRIVE_MAX_A;
    localparam logic signed [15:0]      DRIVE_POS   = 16'sh7FFF;
    localparam logic signed [15:0]      DRIVE_NEG   = 16'sh8001;

    // Turn status codes
    typedef enum logic [1:0] {
        ST_RUN      = 2'd0,
        ST_SETTLED  = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_DISABLED = 2'd3
    } status_t;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_TARGET  = 3'd0,
        REG_GPROP   = 3'd1,
        REG_GINTEG  = 3'd2,
        REG_GDERIV  = 3'd3,
        REG_SCALE   = 3'd4,
        REG_BAND    = 3'd5,
        REG_NEEDED  = 3'd6,
        REG_TIMEOUT = 3'd7
    } cfg_idx_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        M_NONE   = 3'd0,
        M_P_ERR  = 3'd1,
        M_I_LO   = 3'd2,
        M_I_HI   = 3'd3,
        M_D_DIFF = 3'd4,
        M_S_LO   = 3'd5,
        M_S_HI   = 3'd6
    } mul_sel_t;

    // Accumulator operations
    typedef enum logic [1:0] {
        ACC_KEEP   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD    = 2'd2,
        ACC_ADD_HI = 2'd3
    } acc_op_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_EVAL  = 3'd1,
        OP_INTEG = 3'd2,
        OP_CLAMP = 3'd3,
        OP_FINAL = 3'd4,
        OP_DONE  = 3'd5
    } dp_op_t;

    // Sequencer flow
    typedef enum logic [1:0] {
        FL_NEXT    = 2'd0,
        FL_BR_STOP = 2'd1,
        FL_END     = 2'd2
    } flow_t;

    typedef struct packed {
        mul_sel_t          mul;
        acc_op_t           acc;
        dp_op_t            op;
        flow_t             flow;
        logic [STEP_W-1:0] target;
    } ucode_t;

    localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(11);

    // Control program: multiply in one step, accumulate the product in the next
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            4'd0:    w = '{M_NONE,   ACC_KEEP,   OP_EVAL,  FL_BR_STOP, STEP_DONE};
            4'd1:    w = '{M_P_ERR,  ACC_KEEP,   OP_INTEG, FL_NEXT,    STEP_DONE};
            4'd2:    w = '{M_I_LO,   ACC_LOAD,   OP_NONE,  FL_NEXT,    STEP_DONE};
            4'd3:    w = '{M_I_HI,   ACC_ADD,    OP_NONE,  FL_NEXT,    STEP_DONE};
            4'd4:    w = '{M_D_DIFF, ACC_ADD_HI, OP_NONE,  FL_NEXT,    STEP_DONE};
            4'd5:    w = '{M_NONE,   ACC_ADD,    OP_NONE,  FL_NEXT,    STEP_DONE};
            4'd6:    w = '{M_NONE,   ACC_KEEP,   OP_CLAMP, FL_NEXT,    STEP_DONE};
            4'd7:    w = '{M_S_LO,   ACC_KEEP,   OP_NONE,  FL_NEXT,    STEP_DONE};
            4'd8:    w = '{M_S_HI,   ACC_LOAD,   OP_NONE,  FL_NEXT,    STEP_DONE};
            4'd9:    w = '{M_NONE,   ACC_ADD_HI, OP_NONE,  FL_NEXT,    STEP_DONE};
            4'd10:   w = '{M_NONE,   ACC_KEEP,   OP_FINAL, FL_END,     STEP_DONE};
            default: w = '{M_NONE,   ACC_KEEP,   OP_DONE,  FL_END,     STEP_DONE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pid_heading_turn_controller_core.sv =====
// Heading turn controller: one heading sample per beat in, one drive beat out
// (left drive, right drive = -left, turn status). A running tick uses the
// single shared 25x17 multiplier that forms the three gain products and the
// two halves of the drive scaling in turn under a microcoded step counter; a
// tick that finds the turn finished, disabled or timed out skips them. The next
// sample is accepted in the cycle the result is handed to the output register.
// The user must write configuration over the APB port while no tick is in
// work; the block itself does not enforce this.
module pid_heading_turn_controller_core
    import phtc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] heading_sample, [16] run_enable, [17] restart, [23:18] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata: [15:0] left_drive, [31:16] right_drive, [33:32] turn_status,
    //          [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [15:0] target_reg, gp_reg, gi_reg, gd_reg, band_reg, timeout_reg;
    logic [16:0] scale_reg;
    logic [7:0]  need_reg;
    cfg_idx_t    cfg_idx;
    logic        cfg_we;

    // Sequencer
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            cw;
    logic              out_free, end_go, accept, stop;

    // Controller state
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   prev_reg, prev_next;
    logic [7:0]                run_reg, run_next;
    logic [15:0]               tick_reg, tick_next;
    status_t                   fin_reg, fin_next;

    // Working registers
    logic signed [15:0]      smp_reg;
    logic                    en_reg, rst_reg;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_left_reg, out_left_next;
    logic signed [15:0] out_right_reg, out_right_next;
    status_t            out_status_reg, out_status_next;

    // Arithmetic
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]  acc, rnd, shd;
    logic signed [ERR_W-1:0]  err_calc;
    logic signed [INTEG_W:0]  integ_add;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [SUM_W-1:0]  sum_clamp;
    logic signed [15:0]       drive_d, left_calc;
    logic [ERR_W-1:0]         mag;
    logic [7:0]               run_calc;
    status_t                  fin_eff, fin_eval;
    logic [15:0]              tick_eff;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[4:2]);
    assign cfg_we  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_TARGET:  prdata = {16'd0, target_reg};
            REG_GPROP:   prdata = {16'd0, gp_reg};
            REG_GINTEG:  prdata = {16'd0, gi_reg};
            REG_GDERIV:  prdata = {16'd0, gd_reg};
            REG_SCALE:   prdata = {15'd0, scale_reg};
            REG_BAND:    prdata = {16'd0, band_reg};
            REG_NEEDED:  prdata = {24'd0, need_reg};
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= 16'd9000;
            gp_reg      <= 16'd1024;
            gi_reg      <= 16'd6;
            gd_reg      <= 16'd256;
            scale_reg   <= 17'd0;
            band_reg    <= 16'd300;
            need_reg    <= 8'd5;
            timeout_reg <= 16'd50;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_TARGET:  target_reg  <= pwdata[15:0];
                REG_GPROP:   gp_reg      <= pwdata[15:0];
                REG_GINTEG:  gi_reg      <= pwdata[15:0];
                REG_GDERIV:  gd_reg      <= pwdata[15:0];
                REG_SCALE:   scale_reg   <= pwdata[16:0];
                REG_BAND:    band_reg    <= pwdata[15:0];
                REG_NEEDED:  need_reg    <= pwdata[7:0];
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
            endcase
        end
    end

    // Handshakes
    assign cw       = ucode_rom(step_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign end_go   = busy_reg && (cw.flow == FL_END) && out_free;
    assign s_tready = !busy_reg || end_go;
    assign accept   = s_tvalid && s_tready;

    // Tick qualification, with restart applied first
    assign fin_eff  = rst_reg ? ST_RUN : fin_reg;
    assign tick_eff = rst_reg ? 16'd0 : tick_reg;
    assign stop     = (fin_eff != ST_RUN) || !en_reg || (tick_eff >= timeout_reg);

    always_comb begin
        if (fin_eff != ST_RUN)           fin_eval = fin_eff;
        else if (!en_reg)                fin_eval = ST_DISABLED;
        else if (tick_eff >= timeout_reg) fin_eval = ST_TIMEOUT;
        else                             fin_eval = ST_RUN;
    end

    // Step counter
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            unique case (cw.flow)
                FL_END: begin
                    if (out_free) busy_next = 1'b0;
                end
                FL_BR_STOP: begin
                    step_next = stop ? cw.target : step_reg + STEP_W'(1);
                end
                FL_NEXT: begin
                    step_next = step_reg + STEP_W'(1);
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Multiplier operand select
    always_comb begin
        unique case (cw.mul)
            M_P_ERR: begin
                mul_a = MA_W'(err_reg);
                mul_b = $signed({1'b0, gp_reg});
            end
            M_I_LO: begin
                mul_a = $signed({1'b0, integ_reg[HI_SHIFT-1:0]});
                mul_b = $signed({1'b0, gi_reg});
            end
            M_I_HI: begin
                mul_a = MA_W'($signed(integ_reg[INTEG_W-1:HI_SHIFT]));
                mul_b = $signed({1'b0, gi_reg});
            end
            M_D_DIFF: begin
                mul_a = MA_W'(diff_reg);
                mul_b = $signed({1'b0, gd_reg});
            end
            M_S_LO: begin
                mul_a = $signed({1'b0, sum_reg[HI_SHIFT-1:0]});
                mul_b = $signed(scale_reg);
            end
            M_S_HI: begin
                mul_a = MA_W'($signed(sum_reg[SUM_W-1:HI_SHIFT]));
                mul_b = $signed(scale_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    phtc_mac u_mac (
        .aclk   (aclk),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .acc_op (cw.acc),
        .acc    (acc)
    );

    // Error, saturating integral and derivative
    assign err_calc  = $signed({target_reg[15], target_reg}) - $signed({smp_reg[15], smp_reg});
    assign integ_add = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_reg);
    assign integ_sat = (integ_add[INTEG_W] != integ_add[INTEG_W-1])
                     ? (integ_add[INTEG_W] ? INTEG_MIN : INTEG_MAX)
                     : integ_add[INTEG_W-1:0];
    assign diff_next = DIFF_W'(err_reg) - DIFF_W'(prev_reg);

    // Clamp the weighted sum
    always_comb begin
        if (acc > SUM_MAX_A)      sum_clamp = SUM_MAX_A[SUM_W-1:0];
        else if (acc < SUM_MIN_A) sum_clamp = SUM_MIN_A[SUM_W-1:0];
        else                      sum_clamp = acc[SUM_W-1:0];
    end

    // Round half up to Q15 and saturate the drive
    assign rnd = acc + ROUND_HALF;
    assign shd = rnd >>> DRIVE_SHIFT;

    always_comb begin
        if (shd > DRIVE_MAX_A)      drive_d = DRIVE_POS;
        else if (shd < DRIVE_MIN_A) drive_d = DRIVE_NEG;
        else                        drive_d = shd[15:0];
    end

    always_comb begin
        if (target_reg[15])           left_calc = drive_d;
        else if (target_reg == 16'd0) left_calc = 16'sd0;
        else                          left_calc = -drive_d;
    end

    // Settle band tracking
    assign mag = err_reg[ERR_W-1] ? $unsigned(-err_reg) : $unsigned(err_reg);

    always_comb begin
        if (mag < {1'b0, band_reg})
            run_calc = (run_reg == 8'hFF) ? run_reg : run_reg + 8'd1;
        else
            run_calc = 8'd0;
    end

    // Datapath operations
    always_comb begin
        integ_next      = integ_reg;
        prev_next       = prev_reg;
        run_next        = run_reg;
        tick_next       = tick_reg;
        fin_next        = fin_reg;
        err_next        = err_reg;
        sum_next        = sum_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_status_next = out_status_reg;
        if (busy_reg) begin
            unique case (cw.op)
                OP_EVAL: begin
                    err_next = err_calc;
                    fin_next = fin_eval;
                    if (rst_reg) begin
                        integ_next = '0;
                        prev_next  = '0;
                        run_next   = '0;
                        tick_next  = '0;
                    end
                end
                OP_INTEG: begin
                    integ_next = integ_sat;
                end
                OP_CLAMP: begin
                    sum_next = sum_clamp;
                end
                OP_FINAL: begin
                    if (out_free) begin
                        run_next        = run_calc;
                        prev_next       = err_reg;
                        tick_next       = (tick_reg == 16'hFFFF) ? tick_reg
                                                                 : tick_reg + 16'd1;
                        fin_next        = (run_calc >= need_reg) ? ST_SETTLED : ST_RUN;
                        out_left_next   = left_calc;
                        out_right_next  = -left_calc;
                        out_status_next = (run_calc >= need_reg) ? ST_SETTLED : ST_RUN;
                    end
                end
                OP_DONE: begin
                    if (out_free) begin
                        out_left_next   = 16'sd0;
                        out_right_next  = 16'sd0;
                        out_status_next = fin_reg;
                    end
                end
                OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Output valid: load on a finished tick, drop when taken
    always_comb begin
        if (end_go)        out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
        else               out_valid_next = out_valid_reg;
    end

    // Control and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            run_reg       <= '0;
            tick_reg      <= '0;
            fin_reg       <= ST_RUN;
        end else begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            run_reg       <= run_next;
            tick_reg      <= tick_next;
            fin_reg       <= fin_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            smp_reg <= $signed(s_tdata[15:0]);
            en_reg  <= s_tdata[16];
            rst_reg <= s_tdata[17];
        end
        err_reg        <= err_next;
        diff_reg       <= (busy_reg && cw.op == OP_INTEG) ? diff_next : diff_reg;
        sum_reg        <= sum_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_right_reg, out_left_reg};

`ifndef SYNTH
    a_mirror_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[31:16] + m_tdata[15:0]) == 16'd0))
        else $error("right drive is not the negation of left drive");

    a_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[33:32] == ST_TIMEOUT || m_tdata[33:32] == ST_DISABLED))
        |-> (m_tdata[15:0] == 16'd0))
        else $error("nonzero drive on a stopped turn");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg <= STEP_DONE))
        else $error("step counter outside the control program");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (busy_reg && step_reg == '0))
        else $error("accepted beat did not start the program");
`endif

endmodule

// ===== rtl/phtc_mac.sv =====
module phtc_mac
    import phtc_pkg::*;
(
    input  logic                    aclk,
    input  logic signed [MA_W-1:0]  mul_a,
    input  logic signed [MB_W-1:0]  mul_b,
    input  acc_op_t                 acc_op,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    // Multiply into a register, accumulate on the next step
    assign prod_next = mul_a * mul_b;
    assign prod_ext  = $signed({{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg});

    always_comb begin
        unique case (acc_op)
            ACC_KEEP:   acc_next = acc_reg;
            ACC_LOAD:   acc_next = prod_ext;
            ACC_ADD:    acc_next = acc_reg + prod_ext;
            ACC_ADD_HI: acc_next = acc_reg + (prod_ext <<< HI_SHIFT);
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule
